// File: src/scd_pkg.sv
// ----------------------------------------------------------------------------
// scd_pkg
// Shared constants for the scratchpad crc and temperature decoder.
// ----------------------------------------------------------------------------
package scd_pkg;

    localparam int FRAME_BYTES = 9;
    localparam int POS_W       = 5;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] POS_TEMP_LOW  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_TEMP_HIGH = POS_W'(1);
    localparam logic [POS_W-1:0] POS_CONFIG    = POS_W'(4);

    localparam logic [7:0] CRC_POLY = 8'h8C;

    localparam logic [1:0] RES_9BIT  = 2'd0;
    localparam logic [1:0] RES_10BIT = 2'd1;
    localparam logic [1:0] RES_11BIT = 2'd2;
    localparam logic [1:0] RES_12BIT = 2'd3;

    localparam logic signed [15:0] CENTI_MAX = 16'sh7FFF;
    localparam logic signed [15:0] CENTI_MIN = -16'sh8000;

endpackage

// File: src/scd_crc8.sv
// ----------------------------------------------------------------------------
// scd_crc8
// Reflected crc-8 update over one byte, bit by bit from the lsb.
// ----------------------------------------------------------------------------
module scd_crc8 (
    input  logic [7:0] crc_in,
    input  logic [7:0] data_in,
    output logic [7:0] crc_out
);
    import scd_pkg::*;

    always_comb begin
        logic [7:0] c;
        logic [7:0] d;
        c = crc_in;
        d = data_in;
        for (int k = 0; k < 8; k++) begin
            if (c[0] ^ d[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
            d = d >> 1;
        end
        crc_out = c;
    end

endmodule

// File: src/scd_temp_decode.sv
// ----------------------------------------------------------------------------
// scd_temp_decode
// Raw reading to hundredths of a degree: resolution mask, times 25,
// divide by 4 rounding half away from zero, saturate to 16 bits signed.
// ----------------------------------------------------------------------------
module scd_temp_decode (
    input  logic [7:0]         temp_low,
    input  logic [7:0]         temp_high,
    input  logic [1:0]         res_bits,
    output logic signed [15:0] centi
);
    import scd_pkg::*;

    logic [15:0]        raw;
    logic [15:0]        masked;
    logic signed [20:0] wide;
    logic signed [20:0] scaled;
    logic               neg;
    logic [20:0]        mag;
    logic [20:0]        mag_rnd;
    logic [18:0]        q;

    assign raw = {temp_high, temp_low};

    always_comb begin
        unique case (res_bits)
            RES_9BIT:  masked = raw & 16'hFFF8;
            RES_10BIT: masked = raw & 16'hFFFC;
            RES_11BIT: masked = raw & 16'hFFFE;
            RES_12BIT: masked = raw;
            default:   masked = raw;
        endcase
    end

    // times 25 as 16 + 8 + 1
    assign wide    = 21'(signed'(masked));
    assign scaled  = (wide <<< 4) + (wide <<< 3) + wide;
    assign neg     = scaled[20];
    assign mag     = neg ? 21'(-scaled) : 21'(scaled);
    assign mag_rnd = mag + 21'd2;
    assign q       = mag_rnd[20:2];

    always_comb begin
        if (neg) begin
            if (q > 19'd32768) begin
                centi = CENTI_MIN;
            end else begin
                centi = signed'(16'(-q));
            end
        end else begin
            if (q > 19'd32767) begin
                centi = CENTI_MAX;
            end else begin
                centi = signed'(q[15:0]);
            end
        end
    end

endmodule

// File: src/scratchpad_crc_temp_decoder_core.sv
// ----------------------------------------------------------------------------
// scratchpad_crc_temp_decoder_core
// Path: the last byte passes the input register, then crc/decode logic into
// the result register, which drives m_tvalid.
// Throughput: one byte per cycle, both registers stalled only while a result
// waits.
// Reset: synchronous active-low aresetn clears crc, byte position, stored
// temperature and resolution fields and both valid flags.
// ----------------------------------------------------------------------------
module scratchpad_crc_temp_decoder_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] temp_centi
    output logic        m_tuser    // [0] crc_ok
);
    import scd_pkg::*;

    logic               stall;
    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               in_start_reg;
    logic [7:0]         crc_reg;
    logic [7:0]         crc_next;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_eff;
    logic [7:0]         crc_eff;
    logic               last_byte;
    logic [7:0]         temp_low_reg;
    logic [7:0]         temp_high_reg;
    logic [1:0]         res_reg;
    logic signed [15:0] centi;
    logic               out_valid_reg;
    logic [15:0]        out_centi_reg;
    logic               out_crc_ok_reg;

    assign stall    = out_valid_reg && !m_tready;
    assign s_tready = !stall;

    assign pos_eff   = in_start_reg ? '0 : pos_reg;
    assign crc_eff   = in_start_reg ? 8'h00 : crc_reg;
    assign last_byte = pos_eff >= LAST_POS;

    scd_crc8 u_crc (
        .crc_in  (crc_eff),
        .data_in (in_byte_reg),
        .crc_out (crc_next)
    );

    scd_temp_decode u_decode (
        .temp_low  (temp_low_reg),
        .temp_high (temp_high_reg),
        .res_bits  (res_reg),
        .centi     (centi)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (!stall) begin
            in_valid_reg <= s_tvalid;
        end
        if (!stall && s_tvalid) begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
    end

    // frame state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg       <= 8'h00;
            pos_reg       <= '0;
            temp_low_reg  <= 8'h00;
            temp_high_reg <= 8'h00;
            res_reg       <= RES_9BIT;
            out_valid_reg <= 1'b0;
        end else if (!stall) begin
            out_valid_reg <= 1'b0;
            if (in_valid_reg) begin
                if (pos_eff == POS_TEMP_LOW) begin
                    temp_low_reg <= in_byte_reg;
                end else if (pos_eff == POS_TEMP_HIGH) begin
                    temp_high_reg <= in_byte_reg;
                end else if (pos_eff == POS_CONFIG) begin
                    res_reg <= in_byte_reg[6:5];
                end
                if (last_byte) begin
                    crc_reg       <= 8'h00;
                    pos_reg       <= '0;
                    out_valid_reg <= 1'b1;
                end else begin
                    crc_reg <= crc_next;
                    pos_reg <= pos_eff + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!stall && in_valid_reg && last_byte) begin
            out_centi_reg  <= 16'(centi);
            out_crc_ok_reg <= (crc_eff == in_byte_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_centi_reg;
    assign m_tuser  = out_crc_ok_reg;

`ifndef SYNTH
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= LAST_POS)
        else $error("byte position beyond frame length");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(in_valid_reg))
        else $error("result without a byte in the input register");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |-> (!s_tready ##1 $stable(pos_reg)))
        else $error("input taken or state changed while result stalled");

    a_crc_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> (crc_reg == 8'h00 && pos_reg == '0))
        else $error("frame state not cleared after last byte");
`endif

endmodule

// File: test/tb_scratchpad_crc_temp_decoder_core.sv
// ----------------------------------------------------------------------------
// tb_scratchpad_crc_temp_decoder_core
// Streams scratchpad bytes into the decoder and checks every result against
// a cycle-free model of the crc check and temperature scaling. Frames are
// mostly well formed with random content, mixed with bad crc bytes, frames
// cut short by a new frame start and loose bytes. Both sides stall at random,
// the receiver once holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_scratchpad_crc_temp_decoder_core;

    import scd_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } scratch_byte_t;

    typedef struct packed {
        logic               crc_ok;
        logic signed [15:0] centi;
    } reading_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;  // [7:0] data_byte
    logic        s_tuser  = 1'b0;   // [0] frame_start
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [15:0] temp_centi
    logic        m_tuser;           // [0] crc_ok

    scratch_byte_t pending_bytes[$];
    reading_t      reading_expect[$];

    // model state
    logic [7:0]       frame_crc = 8'h00;
    logic [POS_W-1:0] frame_pos = '0;
    logic [7:0]       temp_lo   = 8'h00;
    logic [7:0]       temp_hi   = 8'h00;
    logic [1:0]       res_code  = RES_9BIT;

    int   error_count   = 0;
    int   items_queued  = 0;
    int   idle_pct      = 0;
    int   tx_gap        = 0;
    int   rx_gap        = 0;
    int   rx_hold_cnt   = 0;
    bit   rx_hold_armed = 1'b0;
    bit   rx_hold_done  = 1'b0;
    bit   at_boundary   = 1'b1;
    scratch_byte_t nxt_byte;
    reading_t      got_reading;
    reading_t      want_reading;

    scratchpad_crc_temp_decoder_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 aclk = ~aclk;

    function automatic logic [7:0] crc8_byte(logic [7:0] crc, logic [7:0] b);
        for (int k = 0; k < 8; k++) begin
            if (crc[0] ^ b[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
            b = b >> 1;
        end
        return crc;
    endfunction

    function automatic logic signed [15:0] centi_of(logic [15:0] raw, logic [1:0] res);
        int scaled;
        int mag;
        int q;
        case (res)
            RES_9BIT:  raw[2:0] = 3'b000;
            RES_10BIT: raw[1:0] = 2'b00;
            RES_11BIT: raw[0]   = 1'b0;
            default:   ;
        endcase
        scaled = int'($signed(raw)) * 25;
        mag = (scaled < 0) ? -scaled : scaled;
        q = (mag + 2) / 4;
        if (scaled < 0) begin
            return (q > 32768) ? CENTI_MIN : 16'(-q);
        end
        return (q > 32767) ? CENTI_MAX : 16'(q);
    endfunction

    // advance the model by one accepted byte
    function automatic void decode_byte(logic [7:0] b, logic start);
        logic [POS_W-1:0] p;
        reading_t r;
        if (start) begin
            frame_pos = '0;
            frame_crc = 8'h00;
        end
        p = frame_pos;
        if (p == POS_TEMP_LOW) begin
            temp_lo = b;
        end else if (p == POS_TEMP_HIGH) begin
            temp_hi = b;
        end else if (p == POS_CONFIG) begin
            res_code = b[6:5];
        end
        if (p >= LAST_POS) begin
            r.crc_ok = (frame_crc == b);
            r.centi  = centi_of({temp_hi, temp_lo}, res_code);
            reading_expect.push_back(r);
            frame_pos = '0;
            frame_crc = 8'h00;
        end else begin
            frame_crc = crc8_byte(frame_crc, b);
            frame_pos = p + 1'b1;
        end
    endfunction

    task automatic queue_byte(logic [7:0] b, logic start);
        scratch_byte_t sb;
        sb.data  = b;
        sb.start = start;
        pending_bytes.push_back(sb);
        items_queued++;
    endtask

    task automatic queue_frame(logic [15:0] raw, logic [1:0] res, bit good, bit start,
                               logic [7:0] fill, bit rand_fill);
        logic [7:0] fb [FRAME_BYTES];
        logic [7:0] crc;
        for (int i = 0; i < FRAME_BYTES - 1; i++) begin
            fb[i] = rand_fill ? 8'($urandom) : fill;
        end
        fb[POS_TEMP_LOW]      = raw[7:0];
        fb[POS_TEMP_HIGH]     = raw[15:8];
        fb[POS_CONFIG][6:5]   = res;
        crc = 8'h00;
        for (int i = 0; i < FRAME_BYTES - 1; i++) begin
            crc = crc8_byte(crc, fb[i]);
        end
        fb[FRAME_BYTES-1] = good ? crc : crc ^ 8'($urandom_range(1, 255));
        for (int i = 0; i < FRAME_BYTES; i++) begin
            queue_byte(fb[i], (i == 0) && start);
        end
        at_boundary = 1'b1;
    endtask

    task automatic queue_random(int count);
        int stop_at;
        int kind;
        int n;
        bit start;
        logic [15:0] raw;
        stop_at = items_queued + count;
        while (items_queued < stop_at) begin
            kind = $urandom_range(0, 9);
            if ($urandom_range(0, 1) == 0) begin
                raw = 16'($urandom);
            end else begin
                // mostly inside the range that does not saturate
                raw = 16'($urandom_range(0, 10600) - 5300);
            end
            start = !at_boundary || ($urandom_range(0, 3) != 0);
            case (kind)
                6: queue_frame(raw, 2'($urandom), 1'b0, start, 8'h00, 1'b1);
                7: begin
                    // frame cut short, the next one restarts mid-frame
                    n = $urandom_range(1, FRAME_BYTES - 1);
                    queue_byte(8'($urandom), 1'b1);
                    repeat (n - 1) queue_byte(8'($urandom), 1'b0);
                    at_boundary = 1'b0;
                end
                8: begin
                    repeat ($urandom_range(1, 4)) begin
                        queue_byte(8'($urandom), $urandom_range(0, 3) == 0);
                    end
                    at_boundary = 1'b0;
                end
                default: queue_frame(raw, 2'($urandom), 1'b1, start, 8'h00, 1'b1);
            endcase
        end
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || s_tvalid || reading_expect.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                decode_byte(s_tdata, s_tuser);
            end
            if (s_tvalid && !s_tready) begin
                // hold the offered transfer
            end else if (tx_gap != 0) begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
                nxt_byte = pending_bytes.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt_byte.data;
                s_tuser  <= nxt_byte.start;
                if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                    tx_gap = $urandom_range(1, 6);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_hold_cnt != 0) begin
            rx_hold_cnt--;
            m_tready <= 1'b0;
        end else if (rx_hold_armed && !rx_hold_done) begin
            rx_hold_done = 1'b1;
            rx_hold_cnt = 80;
            m_tready <= 1'b0;
        end else if (rx_gap != 0) begin
            rx_gap--;
            m_tready <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            rx_gap = $urandom_range(0, 5);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_reading.crc_ok = m_tuser;
            got_reading.centi  = m_tdata;
            if (reading_expect.size() == 0) begin
                $error("unexpected result transfer: crc_ok %0d temp_centi %0d",
                       got_reading.crc_ok, got_reading.centi);
                error_count++;
            end else begin
                want_reading = reading_expect.pop_front();
                if (got_reading.crc_ok !== want_reading.crc_ok) begin
                    $error("crc_ok mismatch: expected %0d, actual %0d",
                           want_reading.crc_ok, got_reading.crc_ok);
                    error_count++;
                end
                if (got_reading.centi !== want_reading.centi) begin
                    $error("temp_centi mismatch: expected %0d, actual %0d",
                           want_reading.centi, got_reading.centi);
                    error_count++;
                end
            end
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: saturation both ways, implicit start, bad crc, restart
        idle_pct = 15;
        queue_frame(16'h7FFF, RES_12BIT, 1'b1, 1'b1, 8'hFF, 1'b0);
        queue_frame(16'h8000, RES_9BIT, 1'b0, 1'b0, 8'h00, 1'b0);
        queue_byte(8'h5A, 1'b1);
        queue_byte(8'hA5, 1'b0);
        queue_frame(16'hFFFF, RES_11BIT, 1'b1, 1'b1, 8'h00, 1'b1);
        wait_drained();

        idle_pct = 25;
        queue_random(220);
        while (reading_expect.size() == 0) @(negedge aclk);
        rx_hold_armed = 1'b1;
        // no new bytes are queued until all results are back
        wait_drained();

        idle_pct = 40;
        queue_random(230);
        while (pending_bytes.size() > 80) @(negedge aclk);
        idle_pct = 0;
        wait_drained();

        repeat (10) @(posedge aclk);
        if (error_count == 0 && reading_expect.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
